[hw/rtl/lfgb_pkg.sv]
// ----------------------------------------------------------------------------
// lfgb_pkg: shared types and constants
// Transaction payloads, default sizes and load limits for the longest-first
// greedy balancer.
// ----------------------------------------------------------------------------
package lfgb_pkg;

   // default sizes
   localparam int DEF_MAX_JOBS    = 64;
   localparam int DEF_MAX_WORKERS = 16;
   localparam int DEF_LENGTH_BITS = 24;

   // load accumulator
   localparam int          LOAD_BITS = 30;
   localparam logic [29:0] LOAD_MAX  = 30'h3FFF_FFFF;

   // worker count register
   localparam int         WORKER_COUNT_BITS  = 5;
   localparam logic [4:0] WORKER_COUNT_RESET = 5'd1;

   // input transaction
   typedef struct packed {
      logic [23:0] job_length;
      logic        is_last;
   } lfgb_req_type;

   // result transaction
   typedef struct packed {
      logic [5:0]  job_index;
      logic [3:0]  worker_index;
      logic [29:0] worker_load;
      logic        overflow;
      logic        last_of_run;
   } lfgb_rsp_type;

   // flags that travel with a job from the sort chain to the balancer
   typedef struct packed {
      logic first;
      logic last;
      logic overflow;
   } lfgb_job_ctl_type;

endpackage

[hw/rtl/longest_first_greedy_balance.sv]
// ----------------------------------------------------------------------------
// longest_first_greedy_balance: longest-first greedy job balancer
// Sorts a batch of job lengths longest first in a systolic chain and hands
// each job to the least loaded worker.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one job length per transaction; is_last closes the batch.
//   Jobs beyond MAX_JOBS are dropped and the batch's results carry overflow.
//   rsp_* returns one transaction per stored job, longest first, with the
//   chosen worker and its load after the job; last_of_run marks the final one.
//   csr_wr_en/csr_wr_data set the worker count; write it only while idle.
// Timing:
//   While a batch loads, one job is taken every cycle. After the final job
//   the sort chain settles, then each job is handed to the balancer, which
//   scans the worker loads one per cycle (up to the clamped worker count).
//   A new batch can load while the result for the final job of the previous
//   one is still being computed.
// Reset clears the chain, the counters and the output register and sets the
// worker count to one. When the receiver stalls the result is held in the
// output register; the balancer finishes the scan for its current job and then waits.
// ----------------------------------------------------------------------------
module longest_first_greedy_balance
   import lfgb_pkg::*;
#(
   parameter int MAX_JOBS    = DEF_MAX_JOBS,
   parameter int MAX_WORKERS = DEF_MAX_WORKERS,
   parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  lfgb_req_type                 req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output lfgb_rsp_type                 rsp_data,
   input  logic                         csr_wr_en,
   input  logic [WORKER_COUNT_BITS-1:0] csr_wr_data
);

   localparam int JOB_IDX_BITS = $clog2(MAX_JOBS);
   localparam int COUNT_BITS   = $clog2(MAX_JOBS + 1);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_FLUSH,
      ST_ASSIGN
   } state_type;

   state_type                    state_ff;
   logic [COUNT_BITS-1:0]        count_ff;
   logic [COUNT_BITS-1:0]        flush_ff;
   logic                         dropped_ff;
   logic                         run_drop_ff;
   logic                         first_ff;
   logic [WORKER_COUNT_BITS-1:0] worker_count_ff;

   logic                    req_fire;
   logic                    full;
   logic                    pop;
   logic                    job_ready;
   lfgb_job_ctl_type        job_ctl;

   // chain wiring: pass_* [k] feeds cell k, st_* [k] is cell k's held job
   logic                    pass_v [MAX_JOBS+1];
   logic [LENGTH_BITS-1:0]  pass_l [MAX_JOBS+1];
   logic [JOB_IDX_BITS-1:0] pass_i [MAX_JOBS+1];
   logic                    st_v   [MAX_JOBS+1];
   logic [LENGTH_BITS-1:0]  st_l   [MAX_JOBS+1];
   logic [JOB_IDX_BITS-1:0] st_i   [MAX_JOBS+1];

   assign req_ready = (state_ff == ST_LOAD);
   assign req_fire  = req_valid && req_ready;
   assign full      = (count_ff == COUNT_BITS'(MAX_JOBS));
   assign pop       = (state_ff == ST_ASSIGN) && st_v[0] && job_ready;

   // head of chain takes the masked job length
   assign pass_v[0] = req_fire && !full;
   assign pass_l[0] = LENGTH_BITS'(req_data.job_length);
   assign pass_i[0] = count_ff[JOB_IDX_BITS-1:0];

   // empty entry beyond the tail
   assign st_v[MAX_JOBS] = 1'b0;
   assign st_l[MAX_JOBS] = '0;
   assign st_i[MAX_JOBS] = '0;

   for (genvar k = 0; k < MAX_JOBS; k++) begin : g_cell
      lfgb_sort_cell #(
         .LENGTH_BITS  (LENGTH_BITS),
         .JOB_IDX_BITS (JOB_IDX_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .pop        (pop),
         .ins_valid  (pass_v[k]),
         .ins_len    (pass_l[k]),
         .ins_idx    (pass_i[k]),
         .nxt_valid  (st_v[k+1]),
         .nxt_len    (st_l[k+1]),
         .nxt_idx    (st_i[k+1]),
         .st_valid   (st_v[k]),
         .st_len     (st_l[k]),
         .st_idx     (st_i[k]),
         .pass_valid (pass_v[k+1]),
         .pass_len   (pass_l[k+1]),
         .pass_idx   (pass_i[k+1])
      );
   end

   // flags for the job at the head
   assign job_ctl.first    = first_ff;
   assign job_ctl.last     = !st_v[1];
   assign job_ctl.overflow = run_drop_ff;

   // batch control: load, let the chain settle, hand out jobs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_LOAD;
         count_ff        <= '0;
         flush_ff        <= '0;
         dropped_ff      <= 1'b0;
         run_drop_ff     <= 1'b0;
         first_ff        <= 1'b1;
         worker_count_ff <= WORKER_COUNT_RESET;
      end else begin
         if (csr_wr_en) begin
            worker_count_ff <= csr_wr_data;
         end
         unique case (state_ff)
            ST_LOAD: begin
               if (req_fire) begin
                  if (req_data.is_last) begin
                     run_drop_ff <= dropped_ff || full;
                     dropped_ff  <= 1'b0;
                     count_ff    <= '0;
                     flush_ff    <= '0;
                     state_ff    <= ST_FLUSH;
                  end else if (full) begin
                     dropped_ff <= 1'b1;
                  end else begin
                     count_ff <= count_ff + COUNT_BITS'(1);
                  end
               end
            end
            ST_FLUSH: begin
               if (flush_ff == COUNT_BITS'(MAX_JOBS - 1)) begin
                  first_ff <= 1'b1;
                  state_ff <= ST_ASSIGN;
               end else begin
                  flush_ff <= flush_ff + COUNT_BITS'(1);
               end
            end
            ST_ASSIGN: begin
               if (pop) begin
                  first_ff <= 1'b0;
                  if (job_ctl.last) begin
                     state_ff <= ST_LOAD;
                  end
               end
            end
            default: begin
               state_ff <= ST_LOAD;
            end
         endcase
      end
   end

   lfgb_balancer #(
      .MAX_JOBS    (MAX_JOBS),
      .MAX_WORKERS (MAX_WORKERS),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_balancer (
      .clock        (clock),
      .reset        (reset),
      .worker_count (worker_count_ff),
      .job_valid    (pop),
      .job_ready    (job_ready),
      .job_ctl      (job_ctl),
      .job_len      (st_l[0]),
      .job_idx      (st_i[0]),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

   // no job ever falls off the tail of the chain
   a_tail_empty: assert property (@(posedge clock) disable iff (reset)
      !pass_v[MAX_JOBS])
      else $error("sort chain overflowed at the tail");

   // every batch has a job at the head while assigning
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ASSIGN |-> st_v[0])
      else $error("assign phase with empty chain");

   // the chain is settled before jobs are popped
   a_settled: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ASSIGN |-> !pass_v[1])
      else $error("pop while insertion still in flight");

   // held jobs stay packed toward the head during assignment
   a_packed: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ASSIGN && st_v[1] |-> st_v[0])
      else $error("gap in sort chain");

endmodule

[hw/rtl/lfgb_sort_cell.sv]
// ----------------------------------------------------------------------------
// lfgb_sort_cell: one cell of the systolic sort chain
// Holds one job, keeps the better of held and incoming job, hands the other
// to the right; in pop mode takes over the right neighbor's job.
// ----------------------------------------------------------------------------
module lfgb_sort_cell
   import lfgb_pkg::*;
#(
   parameter int LENGTH_BITS  = DEF_LENGTH_BITS,
   parameter int JOB_IDX_BITS = $clog2(DEF_MAX_JOBS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop,
   input  logic                    ins_valid,
   input  logic [LENGTH_BITS-1:0]  ins_len,
   input  logic [JOB_IDX_BITS-1:0] ins_idx,
   input  logic                    nxt_valid,
   input  logic [LENGTH_BITS-1:0]  nxt_len,
   input  logic [JOB_IDX_BITS-1:0] nxt_idx,
   output logic                    st_valid,
   output logic [LENGTH_BITS-1:0]  st_len,
   output logic [JOB_IDX_BITS-1:0] st_idx,
   output logic                    pass_valid,
   output logic [LENGTH_BITS-1:0]  pass_len,
   output logic [JOB_IDX_BITS-1:0] pass_idx
);

   logic                    st_valid_ff;
   logic [LENGTH_BITS-1:0]  st_len_ff;
   logic [JOB_IDX_BITS-1:0] st_idx_ff;
   logic                    pass_valid_ff;
   logic [LENGTH_BITS-1:0]  pass_len_ff;
   logic [JOB_IDX_BITS-1:0] pass_idx_ff;
   logic                    ins_better;

   // longer first, lower arrival index on equal length
   assign ins_better = (ins_len > st_len_ff) ||
                       ((ins_len == st_len_ff) && (ins_idx < st_idx_ff));

   // hold, swap or pass on; pop shifts toward the head
   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff   <= 1'b0;
         pass_valid_ff <= 1'b0;
      end else if (pop) begin
         st_valid_ff   <= nxt_valid;
         st_len_ff     <= nxt_len;
         st_idx_ff     <= nxt_idx;
         pass_valid_ff <= 1'b0;
      end else if (!ins_valid) begin
         pass_valid_ff <= 1'b0;
      end else if (!st_valid_ff) begin
         st_valid_ff   <= 1'b1;
         st_len_ff     <= ins_len;
         st_idx_ff     <= ins_idx;
         pass_valid_ff <= 1'b0;
      end else if (ins_better) begin
         st_len_ff     <= ins_len;
         st_idx_ff     <= ins_idx;
         pass_valid_ff <= 1'b1;
         pass_len_ff   <= st_len_ff;
         pass_idx_ff   <= st_idx_ff;
      end else begin
         pass_valid_ff <= 1'b1;
         pass_len_ff   <= ins_len;
         pass_idx_ff   <= ins_idx;
      end
   end

   assign st_valid   = st_valid_ff;
   assign st_len     = st_len_ff;
   assign st_idx     = st_idx_ff;
   assign pass_valid = pass_valid_ff;
   assign pass_len   = pass_len_ff;
   assign pass_idx   = pass_idx_ff;

endmodule

[hw/rtl/lfgb_balancer.sv]
// ----------------------------------------------------------------------------
// lfgb_balancer: least-loaded worker search and load update
// Scans the worker loads one per cycle, adds the job to the least loaded
// worker with saturation and registers the result transaction.
// ----------------------------------------------------------------------------
module lfgb_balancer
   import lfgb_pkg::*;
#(
   parameter int MAX_JOBS    = DEF_MAX_JOBS,
   parameter int MAX_WORKERS = DEF_MAX_WORKERS,
   parameter int LENGTH_BITS = DEF_LENGTH_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [WORKER_COUNT_BITS-1:0]       worker_count,
   input  logic                               job_valid,
   output logic                               job_ready,
   input  lfgb_job_ctl_type                   job_ctl,
   input  logic [LENGTH_BITS-1:0]             job_len,
   input  logic [$clog2(MAX_JOBS)-1:0]        job_idx,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output lfgb_rsp_type                       rsp_data
);

   localparam int JOB_IDX_BITS = $clog2(MAX_JOBS);
   localparam int WIDX_BITS    = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int SUM_BITS     = ((LENGTH_BITS > LOAD_BITS) ? LENGTH_BITS : LOAD_BITS) + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

   state_type               state_ff;
   logic [LENGTH_BITS-1:0]  len_ff;
   logic [JOB_IDX_BITS-1:0] idx_ff;
   lfgb_job_ctl_type        ctl_ff;
   logic [WIDX_BITS-1:0]    w_ff;
   logic [WIDX_BITS-1:0]    best_ff;
   logic [LOAD_BITS:0]      best_load_ff;
   logic [LOAD_BITS-1:0]    loads_ff [MAX_WORKERS];
   logic                    rsp_valid_ff;
   lfgb_rsp_type            rsp_data_ff;

   logic [WIDX_BITS-1:0]    last_w;
   logic [LOAD_BITS:0]      cand_load;
   logic [SUM_BITS-1:0]     sum;
   logic [LOAD_BITS-1:0]    new_load;
   logic                    out_free;

   // clamp the worker count to one through MAX_WORKERS
   always_comb begin
      if (worker_count == '0) begin
         last_w = '0;
      end else if (32'(worker_count) > MAX_WORKERS) begin
         last_w = WIDX_BITS'(MAX_WORKERS - 1);
      end else begin
         last_w = WIDX_BITS'(worker_count - 5'd1);
      end
   end

   // candidate, saturating sum
   assign cand_load = {1'b0, loads_ff[w_ff]};
   assign sum       = SUM_BITS'(best_load_ff[LOAD_BITS-1:0]) + SUM_BITS'(len_ff);
   assign new_load  = (sum > SUM_BITS'(LOAD_MAX)) ? LOAD_MAX : sum[LOAD_BITS-1:0];
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // sequence one job: take, scan, update
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the accepted result unless a new one replaces it
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_UPDATE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (job_valid) begin
                  len_ff       <= job_len;
                  idx_ff       <= job_idx;
                  ctl_ff       <= job_ctl;
                  w_ff         <= '0;
                  best_ff      <= '0;
                  best_load_ff <= {1'b1, {LOAD_BITS{1'b0}}};
                  if (job_ctl.first) begin
                     for (int i = 0; i < MAX_WORKERS; i++) begin
                        loads_ff[i] <= '0;
                     end
                  end
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (cand_load < best_load_ff) begin
                  best_ff      <= w_ff;
                  best_load_ff <= cand_load;
               end
               if (w_ff == last_w) begin
                  state_ff <= ST_UPDATE;
               end else begin
                  w_ff <= w_ff + WIDX_BITS'(1);
               end
            end
            ST_UPDATE: begin
               if (out_free) begin
                  loads_ff[best_ff]        <= new_load;
                  rsp_data_ff.job_index    <= 6'(idx_ff);
                  rsp_data_ff.worker_index <= 4'(best_ff);
                  rsp_data_ff.worker_load  <= new_load;
                  rsp_data_ff.overflow     <= ctl_ff.overflow;
                  rsp_data_ff.last_of_run  <= ctl_ff.last;
                  rsp_valid_ff             <= 1'b1;
                  state_ff                 <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign job_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a waiting result is never overwritten
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("result overwritten while stalled");

   // the chosen worker lies within the active worker count
   a_best_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |-> best_ff <= last_w)
      else $error("chosen worker beyond worker count");

   // after the scan the best load is a real load, not the start marker
   a_best_found: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_UPDATE |-> !best_load_ff[LOAD_BITS])
      else $error("scan ended without a candidate");

endmodule

[bench/tb_longest_first_greedy_balance.sv]
// ----------------------------------------------------------------------------
// tb_longest_first_greedy_balance: self-checking bench for the job balancer
// Sends batches of job lengths and predicts every assignment: jobs are
// ordered longest first, and each goes to the least loaded worker. Covers
// worker count extremes, ties, a full store, dropped jobs and long receiver
// hold-off. Results are checked field by field in order.
// ----------------------------------------------------------------------------
module tb_longest_first_greedy_balance;
   import lfgb_pkg::*;

   localparam int RUN_LIMIT   = 400000;
   localparam int IDLE_SETTLE = 2 * DEF_MAX_JOBS;
   localparam int LONG_HOLD   = 800;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   lfgb_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   lfgb_rsp_type rsp_data;
   logic         csr_wr_en = 1'b0;
   logic [WORKER_COUNT_BITS-1:0] csr_wr_data = '0;

   // predictor state
   logic [23:0]  stored_lengths[$];
   logic         batch_dropped = 1'b0;
   logic [4:0]   worker_setting = WORKER_COUNT_RESET;
   lfgb_rsp_type pending_assignments[$];

   // traffic shaping
   int  burst_left = 0;
   int  gap_max = 0;
   int  stall_max = 0;
   logic hold_start = 1'b0;
   int  hold_left = 0;
   int  run_left = 0;

   int  fail_count = 0;
   int  cycle_count = 0;

   longest_first_greedy_balance dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Store one accepted job; on the closing job compute the whole assignment run.
   task automatic absorb_job(input lfgb_req_type job);
      int           rank[DEF_MAX_JOBS];
      logic [29:0]  loads[DEF_MAX_WORKERS];
      int           n;
      int           workers;
      int           best;
      int           j;
      logic [33:0]  sum;
      lfgb_rsp_type rsp;
      if (stored_lengths.size() < DEF_MAX_JOBS) begin
         stored_lengths.insert(stored_lengths.size(), job.job_length);
      end else begin
         batch_dropped = 1'b1;
      end
      if (!job.is_last) return;

      workers = worker_setting;
      if (workers == 0) workers = 1;
      if (workers > DEF_MAX_WORKERS) workers = DEF_MAX_WORKERS;
      for (int w = 0; w < DEF_MAX_WORKERS; w++) loads[w] = '0;
      n = stored_lengths.size();

      // order longest first, equal lengths keep arrival order
      for (int i = 0; i < n; i++) begin
         j = i;
         while (j > 0 && stored_lengths[rank[j-1]] < stored_lengths[i]) begin
            rank[j] = rank[j-1];
            j--;
         end
         rank[j] = i;
      end

      // hand each job to the least loaded worker, lowest index on a tie
      for (int k = 0; k < n; k++) begin
         best = 0;
         for (int w = 1; w < workers; w++) begin
            if (loads[w] < loads[best]) best = w;
         end
         sum = {4'b0, loads[best]} + {10'b0, stored_lengths[rank[k]]};
         loads[best] = (sum > {4'b0, LOAD_MAX}) ? LOAD_MAX : sum[29:0];
         rsp.job_index    = rank[k][5:0];
         rsp.worker_index = best[3:0];
         rsp.worker_load  = loads[best];
         rsp.overflow     = batch_dropped;
         rsp.last_of_run  = (k == n - 1);
         pending_assignments.insert(pending_assignments.size(), rsp);
      end
      stored_lengths.delete();
      batch_dropped = 1'b0;
   endtask

   // Offer one job, hold it until accepted, then maybe pause between bursts.
   task automatic offer_job(input logic [23:0] length, input logic last);
      lfgb_req_type job;
      int           gap;
      job.job_length = length;
      job.is_last    = last;
      req_valid <= 1'b1;
      req_data  <= job;
      do @(posedge clock); while (req_ready !== 1'b1);
      absorb_job(job);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drop valid and wait until every predicted result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_assignments.size() != 0) @(posedge clock);
   endtask

   // Drain, then let the balancer settle so a register write lands while idle.
   task automatic wait_idle();
      drain_results();
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic set_workers(input logic [4:0] count);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      worker_setting = count;
   endtask

   function automatic logic [23:0] pick_length();
      case ($urandom_range(0, 5))
         0:       return 24'h000000;
         1:       return 24'hFFFFFF;
         2, 3:    return 24'($urandom_range(0, 7));
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic send_batch(input int count);
      for (int i = 0; i < count; i++) offer_job(pick_length(), i == count - 1);
   endtask

   // Extremes of length, ties, and the worker count clamps.
   task automatic test_directed();
      gap_max   = 0;
      stall_max = 0;
      // reset worker count of one
      offer_job(24'h000000, 1'b1);
      offer_job(24'hFFFFFF, 1'b1);
      wait_idle();
      set_workers(5'd3);
      offer_job(24'd5, 1'b0);
      offer_job(24'd5, 1'b0);
      offer_job(24'd5, 1'b0);
      offer_job(24'd5, 1'b0);
      offer_job(24'd7, 1'b1);
      wait_idle();
      // zero workers acts as one
      set_workers(5'd0);
      offer_job(24'd1, 1'b0);
      offer_job(24'd2, 1'b0);
      offer_job(24'd3, 1'b1);
      wait_idle();
      // too many workers clamps to the maximum
      set_workers(5'd31);
      repeat (3) offer_job(24'hFFFFFF, 1'b0);
      offer_job(24'hFFFFFF, 1'b1);
      wait_idle();
      set_workers(5'd16);
      offer_job(24'hAAAAAA, 1'b0);
      offer_job(24'h555555, 1'b0);
      offer_job(24'h800001, 1'b1);
      wait_idle();
   endtask

   // Fill the store, drop its tail and closing job, then a clean batch.
   task automatic test_store_full();
      gap_max   = 4;
      stall_max = 6;
      set_workers(5'($urandom_range(1, 16)));
      send_batch(DEF_MAX_JOBS + 2);
      // drop flag must be clear again on the next batch
      send_batch(3);
      wait_idle();
   endtask

   // Random batches over a range of worker counts and traffic patterns.
   task automatic test_random();
      logic [4:0] count;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0:       count = 5'd1;
            1:       count = 5'd16;
            2:       count = 5'd0;
            3:       count = 5'd31;
            default: count = 5'($urandom_range(0, 31));
         endcase
         set_workers(count);
         gap_max   = (phase % 3 == 0) ? 0 : $urandom_range(1, 8);
         stall_max = (phase % 4 == 1) ? 0 : $urandom_range(1, 12);
         send_batch($urandom_range(1, 6));
         wait_idle();
      end
   endtask

   // Hold the receiver off while batches pile up, drain, then send one more batch.
   task automatic test_backpressure();
      gap_max   = 0;
      stall_max = 3;
      set_workers(5'd4);
      hold_start = 1'b1;
      repeat (2) send_batch(8);
      drain_results();
      send_batch(3);
      wait_idle();
   endtask

   // receiver: long hold-off on request, else alternating ready and stall runs
   always @(posedge clock) begin
      if (hold_start) begin
         hold_left  = LONG_HOLD;
         hold_start = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (run_left > 0) begin
         run_left--;
      end else if (!rsp_ready || stall_max == 0) begin
         rsp_ready <= 1'b1;
         run_left = $urandom_range(0, 15);
      end else begin
         rsp_ready <= 1'b0;
         run_left = $urandom_range(0, stall_max - 1);
      end
   end

   task automatic check_field(input string name, input logic [29:0] want,
                              input logic [29:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      lfgb_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (pending_assignments.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp_data);
            fail_count++;
         end else begin
            want = pending_assignments.pop_front();
            check_field("job_index", 30'(want.job_index), 30'(rsp_data.job_index));
            check_field("worker_index", 30'(want.worker_index),
                        30'(rsp_data.worker_index));
            check_field("worker_load", want.worker_load, rsp_data.worker_load);
            check_field("overflow", 30'(want.overflow), 30'(rsp_data.overflow));
            check_field("last_of_run", 30'(want.last_of_run), 30'(rsp_data.last_of_run));
         end
      end
   end

   // bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_store_full();
      test_random();
      test_backpressure();
      wait_idle();
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
